// ===== design/iirdf1_pkg.sv =====
`default_nettype none
package iirdf1_pkg;

  // Field and register widths
  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 18;
  localparam int NUM_REGS    = 8;
  localparam int REG_IDX_W   = 3;
  localparam int CFG_INDEX_W = 4;

  // History depth at the largest order, and the tap select that covers it
  localparam int HIST_DEPTH = 3;
  localparam int TAP_W      = 2;

  localparam int DEF_FORWARD_ORDER  = 3;
  localparam int DEF_FEEDBACK_ORDER = 3;

  // Datapath widths
  localparam int OPND_W     = 20;                 // multiplier operand
  localparam int PROD_W     = OPND_W + COEF_W;    // registered product
  localparam int ACC_W      = 37;                 // sum of seven Q1.15 x Q4.14 products
  localparam int ACC_LO_W   = 18;                 // low slice of the sum, scaled first
  localparam int FIN_W      = 56;                 // scaled sum, Q.43
  localparam int FRAC_SHIFT = 28;                 // Q.43 down to Q.15
  localparam int Q_W        = FIN_W - FRAC_SHIFT;

  localparam logic signed [FIN_W-1:0] ROUND_HALF =
    {{(FIN_W-FRAC_SHIFT){1'b0}}, 1'b1, {(FRAC_SHIFT-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [COEF_W-1:0] COEF_ONE = 18'sd16384;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_B0    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_B1    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_B2    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_B3    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_A1    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_A2    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_A3    = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_RECIP = 3'd7;

  // Microprogram addresses
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_X0       = 4'd0;
  localparam logic [STEP_W-1:0] STEP_B1       = 4'd1;
  localparam logic [STEP_W-1:0] STEP_B2       = 4'd2;
  localparam logic [STEP_W-1:0] STEP_B3       = 4'd3;
  localparam logic [STEP_W-1:0] STEP_FB_START = 4'd4;
  localparam logic [STEP_W-1:0] STEP_A2       = 4'd5;
  localparam logic [STEP_W-1:0] STEP_A3       = 4'd6;
  localparam logic [STEP_W-1:0] STEP_DRAIN    = 4'd7;
  localparam logic [STEP_W-1:0] STEP_SCALE_LO = 4'd8;
  localparam logic [STEP_W-1:0] STEP_SCALE_HI = 4'd9;
  localparam logic [STEP_W-1:0] STEP_SETTLE   = 4'd10;
  localparam logic [STEP_W-1:0] STEP_DONE     = 4'd11;

  typedef enum logic [2:0] {
    SRC_X0, SRC_XH, SRC_YH, SRC_ACC_LO, SRC_ACC_HI
  } src_t;

  typedef enum logic [2:0] {
    OP_NOP, OP_LOAD, OP_ADD, OP_SUB, OP_FLOAD, OP_FADD
  } acc_op_t;

  typedef enum logic [2:0] {
    COND_NONE, COND_FWD_LT2, COND_FWD_LT3, COND_FB_LT2, COND_FB_LT3
  } cond_t;

  // One microcode word
  typedef struct packed {
    src_t                   src;
    logic [TAP_W-1:0]       tap;
    logic [REG_IDX_W-1:0]   coef;
    acc_op_t                op;
    cond_t                  cond;
    logic [STEP_W-1:0]      target;
    logic                   done;
  } ucode_t;

  // Controls from the sequencer to the datapath
  typedef struct packed {
    src_t                   src;
    logic [TAP_W-1:0]       tap;
    logic [REG_IDX_W-1:0]   coef;
    acc_op_t                op;
    logic                   done;
  } ctl_t;

  function automatic ucode_t mk_word(input src_t src, input logic [TAP_W-1:0] tap,
                                     input logic [REG_IDX_W-1:0] coef, input acc_op_t op,
                                     input cond_t cond, input logic [STEP_W-1:0] target,
                                     input logic done);
    ucode_t w;
    w.src    = src;
    w.tap    = tap;
    w.coef   = coef;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    w.done   = done;
    return w;
  endfunction

  // Filter microprogram: taps, drain, scale by 1/a0 in two halves, settle, done
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] addr);
    ucode_t w;
    case (addr)
      STEP_X0:       w = mk_word(SRC_X0, 2'd0, REG_B0, OP_LOAD, COND_NONE, STEP_X0, 1'b0);
      STEP_B1:       w = mk_word(SRC_XH, 2'd0, REG_B1, OP_ADD, COND_NONE, STEP_X0, 1'b0);
      STEP_B2:       w = mk_word(SRC_XH, 2'd1, REG_B2, OP_ADD, COND_FWD_LT2,
                                 STEP_FB_START, 1'b0);
      STEP_B3:       w = mk_word(SRC_XH, 2'd2, REG_B3, OP_ADD, COND_FWD_LT3,
                                 STEP_FB_START, 1'b0);
      STEP_FB_START: w = mk_word(SRC_YH, 2'd0, REG_A1, OP_SUB, COND_NONE, STEP_X0, 1'b0);
      STEP_A2:       w = mk_word(SRC_YH, 2'd1, REG_A2, OP_SUB, COND_FB_LT2,
                                 STEP_DRAIN, 1'b0);
      STEP_A3:       w = mk_word(SRC_YH, 2'd2, REG_A3, OP_SUB, COND_FB_LT3,
                                 STEP_DRAIN, 1'b0);
      STEP_DRAIN:    w = mk_word(SRC_X0, 2'd0, REG_B0, OP_NOP, COND_NONE, STEP_X0, 1'b0);
      STEP_SCALE_LO: w = mk_word(SRC_ACC_LO, 2'd0, REG_RECIP, OP_FLOAD, COND_NONE,
                                 STEP_X0, 1'b0);
      STEP_SCALE_HI: w = mk_word(SRC_ACC_HI, 2'd0, REG_RECIP, OP_FADD, COND_NONE,
                                 STEP_X0, 1'b0);
      STEP_SETTLE:   w = mk_word(SRC_X0, 2'd0, REG_B0, OP_NOP, COND_NONE, STEP_X0, 1'b0);
      STEP_DONE:     w = mk_word(SRC_X0, 2'd0, REG_B0, OP_NOP, COND_NONE, STEP_X0, 1'b1);
      default:       w = mk_word(SRC_X0, 2'd0, REG_B0, OP_NOP, COND_NONE, STEP_X0, 1'b1);
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== design/iirdf1_seq.sv =====
`default_nettype none
module iirdf1_seq #(
  parameter int FORWARD_ORDER  = iirdf1_pkg::DEF_FORWARD_ORDER,
  parameter int FEEDBACK_ORDER = iirdf1_pkg::DEF_FEEDBACK_ORDER
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             out_free,
  output logic                  busy,
  output iirdf1_pkg::ctl_t      ctrl
);
  import iirdf1_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  localparam logic FWD_LT2 = (FORWARD_ORDER < 2);
  localparam logic FWD_LT3 = (FORWARD_ORDER < 3);
  localparam logic FB_LT2  = (FEEDBACK_ORDER < 2);
  localparam logic FB_LT3  = (FEEDBACK_ORDER < 3);

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;
  ucode_t            word;
  logic              jump;

  // Fetch the control word
  always_comb word = ucode_rom(step);

  // Evaluate the jump condition against the configured orders
  always_comb begin
    case (word.cond)
      COND_NONE:    jump = 1'b0;
      COND_FWD_LT2: jump = FWD_LT2;
      COND_FWD_LT3: jump = FWD_LT3;
      COND_FB_LT2:  jump = FB_LT2;
      COND_FB_LT3:  jump = FB_LT3;
      default:      jump = 1'b0;
    endcase
  end

  // Advance the step counter and issue controls
  always_comb begin
    state_next = state;
    step_next  = step;
    ctrl.src   = word.src;
    ctrl.tap   = word.tap;
    ctrl.coef  = word.coef;
    ctrl.op    = OP_NOP;
    ctrl.done  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_RUN;
          step_next  = STEP_X0;
        end
      end
      ST_RUN: begin
        if (jump) begin
          step_next = word.target;
        end else if (word.done) begin
          // hold on the last step until the result register is free
          if (out_free) begin
            ctrl.done  = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          ctrl.op   = word.op;
          step_next = step + {{(STEP_W-1){1'b0}}, 1'b1};
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= STEP_X0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule
`default_nettype wire

// ===== design/iirdf1_dp.sv =====
`default_nettype none
module iirdf1_dp #(
  parameter int FORWARD_ORDER  = iirdf1_pkg::DEF_FORWARD_ORDER,
  parameter int FEEDBACK_ORDER = iirdf1_pkg::DEF_FEEDBACK_ORDER
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      cfg_wr_en,
  input  wire logic [iirdf1_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  wire logic signed [iirdf1_pkg::COEF_W-1:0]      cfg_data,
  input  wire logic                                      load_x,
  input  wire logic signed [iirdf1_pkg::SAMPLE_W-1:0]    sample_in,
  input  iirdf1_pkg::ctl_t                               ctrl,
  output logic signed [iirdf1_pkg::SAMPLE_W-1:0]         y,
  output logic                                           clip
);
  import iirdf1_pkg::*;

  logic signed [COEF_W-1:0]   coef [NUM_REGS];
  logic signed [SAMPLE_W-1:0] x0;
  logic signed [SAMPLE_W-1:0] xh [FORWARD_ORDER];
  logic signed [SAMPLE_W-1:0] yh [FEEDBACK_ORDER];
  logic signed [SAMPLE_W-1:0] xv [HIST_DEPTH];
  logic signed [SAMPLE_W-1:0] yv [HIST_DEPTH];

  logic signed [OPND_W-1:0]   opnd;
  logic signed [COEF_W-1:0]   coef_sel;
  logic signed [PROD_W-1:0]   prod;
  acc_op_t                    op_d;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    prod_acc;
  logic signed [FIN_W-1:0]    fin;
  logic signed [FIN_W-1:0]    prod_fin;
  logic signed [FIN_W-1:0]    prod_fin_hi;
  logic signed [FIN_W-1:0]    rnd;
  logic signed [Q_W-1:0]      q;
  logic                       in_range;

  // Coefficient registers; writes past the last index are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_REGS; k++) begin
        coef[k] <= ((k == int'(REG_B0)) || (k == int'(REG_RECIP))) ? COEF_ONE : '0;
      end
    end else if (cfg_wr_en && (cfg_index < CFG_INDEX_W'(NUM_REGS))) begin
      coef[cfg_index[REG_IDX_W-1:0]] <= cfg_data;
    end
  end

  // Capture the new sample
  always_ff @(posedge clk) begin
    if (load_x) x0 <= sample_in;
  end

  // Shift both histories once the result is committed
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < FORWARD_ORDER; k++) xh[k] <= '0;
      for (int k = 0; k < FEEDBACK_ORDER; k++) yh[k] <= '0;
    end else if (ctrl.done) begin
      xh[0] <= x0;
      for (int k = 1; k < FORWARD_ORDER; k++) xh[k] <= xh[k-1];
      yh[0] <= y;
      for (int k = 1; k < FEEDBACK_ORDER; k++) yh[k] <= yh[k-1];
    end
  end

  // Fixed-depth views of the histories; taps past the order read zero
  for (genvar k = 0; k < HIST_DEPTH; k++) begin : g_view
    if (k < FORWARD_ORDER) begin : g_x
      assign xv[k] = xh[k];
    end else begin : g_xz
      assign xv[k] = '0;
    end
    if (k < FEEDBACK_ORDER) begin : g_y
      assign yv[k] = yh[k];
    end else begin : g_yz
      assign yv[k] = '0;
    end
  end

  // Select the multiplier operand
  always_comb begin
    case (ctrl.src)
      SRC_X0:     opnd = {{(OPND_W-SAMPLE_W){x0[SAMPLE_W-1]}}, x0};
      SRC_XH:     opnd = {{(OPND_W-SAMPLE_W){xv[ctrl.tap][SAMPLE_W-1]}}, xv[ctrl.tap]};
      SRC_YH:     opnd = {{(OPND_W-SAMPLE_W){yv[ctrl.tap][SAMPLE_W-1]}}, yv[ctrl.tap]};
      SRC_ACC_LO: opnd = {{(OPND_W-ACC_LO_W){1'b0}}, acc[ACC_LO_W-1:0]};
      SRC_ACC_HI: opnd = {{(OPND_W-ACC_W+ACC_LO_W){acc[ACC_W-1]}}, acc[ACC_W-1:ACC_LO_W]};
      default:    opnd = '0;
    endcase
  end

  assign coef_sel = coef[ctrl.coef];

  // Multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      op_d <= OP_NOP;
    end else begin
      op_d <= ctrl.op;
    end
  end

  always_ff @(posedge clk) begin
    prod <= opnd * coef_sel;
  end

  assign prod_acc    = prod[ACC_W-1:0];
  assign prod_fin    = {{(FIN_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign prod_fin_hi = {prod_fin[FIN_W-ACC_LO_W-1:0], {ACC_LO_W{1'b0}}};

  // Accumulate stage: tap sum, then the sum scaled by 1/a0
  always_ff @(posedge clk) begin
    case (op_d)
      OP_LOAD:  acc <= prod_acc;
      OP_ADD:   acc <= acc + prod_acc;
      OP_SUB:   acc <= acc - prod_acc;
      OP_FLOAD: fin <= prod_fin;
      OP_FADD:  fin <= fin + prod_fin_hi;
      default:  ;
    endcase
  end

  // Round half up to Q1.15 and saturate
  assign rnd      = fin + ROUND_HALF;
  assign q        = rnd[FIN_W-1:FRAC_SHIFT];
  assign in_range = (q[Q_W-1:SAMPLE_W-1] == '0) || (q[Q_W-1:SAMPLE_W-1] == '1);
  assign y        = in_range ? q[SAMPLE_W-1:0] : (q[Q_W-1] ? SAT_MIN : SAT_MAX);
  assign clip     = !in_range;

endmodule
`default_nettype wire

// ===== design/iir_direct_form_one_filter_core.sv =====
// Direct-form I IIR filter, up to third order forward and feedback, Q1.15 samples and
// Q4.14 coefficients, with the sum scaled by a programmed reciprocal of a0, rounded half
// up and saturated to 16 bits (clipped flags saturation). A microprogram steps one shared
// 20x18 multiplier with a registered product through the taps and the two-part scaling;
// a new item is taken only once the last one has loaded the result register, in the
// cycle after that load, and a forward or feedback order of 1 shortens the run. The
// multiplier pipeline and the number of steps set how long each item takes.
// A result waiting in the output register does not block acceptance; the sequencer holds
// on its last step only if that register is still occupied.
`default_nettype none
module iir_direct_form_one_filter_core #(
  parameter int FORWARD_ORDER  = iirdf1_pkg::DEF_FORWARD_ORDER,
  parameter int FEEDBACK_ORDER = iirdf1_pkg::DEF_FEEDBACK_ORDER
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    cfg_wr_en,
  input  wire logic [iirdf1_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic signed [iirdf1_pkg::COEF_W-1:0]    cfg_data,
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire logic signed [iirdf1_pkg::SAMPLE_W-1:0]  sample_in,
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic signed [iirdf1_pkg::SAMPLE_W-1:0]       sample_out,
  output logic                                         clipped
);
  import iirdf1_pkg::*;

  logic                       accept;
  logic                       out_free;
  logic                       busy;
  ctl_t                       ctrl;
  logic signed [SAMPLE_W-1:0] y;
  logic                       clip;

  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  iirdf1_seq #(
    .FORWARD_ORDER  (FORWARD_ORDER),
    .FEEDBACK_ORDER (FEEDBACK_ORDER)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .out_free (out_free),
    .busy     (busy),
    .ctrl     (ctrl)
  );

  iirdf1_dp #(
    .FORWARD_ORDER  (FORWARD_ORDER),
    .FEEDBACK_ORDER (FEEDBACK_ORDER)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .load_x    (accept),
    .sample_in (sample_in),
    .ctrl      (ctrl),
    .y         (y),
    .clip      (clip)
  );

  // Output register: load on commit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.done) begin
      sample_out <= y;
      clipped    <= clip;
    end
  end

  // An accepted item keeps the input side stalled while it runs
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after an accepted item");

  // A result appears only from a committed item
  a_out_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctrl.done))
    else $error("result appeared without a commit");

  // A clipped result sits on a rail
  a_clip_on_rail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clipped) |-> (sample_out == SAT_MAX || sample_out == SAT_MIN))
    else $error("clipped result not at a rail");

endmodule
`default_nettype wire

// ===== tb/iir_direct_form_one_filter_core_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
module iir_direct_form_one_filter_core_tb;
  import iirdf1_pkg::*;

  localparam int FWD_TAPS   = DEF_FORWARD_ORDER;
  localparam int FB_TAPS    = DEF_FEEDBACK_ORDER;
  localparam int IDLE_WAIT  = 16;     // a little over one item's worth of cycles
  localparam int STALL_MAX  = 2000;   // cycles with no handshake before giving up
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 100;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] y;
    logic                       clip;
  } filt_result_t;

  // Filter predictor plus the queue of outputs it still owes
  class iir_df1_scoreboard;
    logic signed [COEF_W-1:0]   coef [NUM_REGS];
    logic signed [SAMPLE_W-1:0] x_hist [HIST_DEPTH];
    logic signed [SAMPLE_W-1:0] y_hist [HIST_DEPTH];
    filt_result_t               expected_q [$];
    int                         errors;
    int                         results;
    int                         clips;

    function new();
      foreach (coef[i]) coef[i] = '0;
      coef[REG_B0]    = COEF_ONE;
      coef[REG_RECIP] = COEF_ONE;
      foreach (x_hist[i]) begin
        x_hist[i] = '0;
        y_hist[i] = '0;
      end
      errors  = 0;
      results = 0;
      clips   = 0;
    endfunction

    // Indexes past the register file are dropped by the block
    function void write_reg(int unsigned idx, logic signed [COEF_W-1:0] val);
      if (idx < NUM_REGS) coef[idx] = val;
    endfunction

    // Run one sample through the filter and queue the output it must produce
    function void note_input(logic signed [SAMPLE_W-1:0] x);
      longint       acc;
      longint       q;
      filt_result_t r;
      acc = longint'(coef[REG_B0]) * longint'(x);
      for (int j = 0; j < FWD_TAPS; j++)
        acc += longint'(coef[int'(REG_B1) + j]) * longint'(x_hist[j]);
      for (int j = 0; j < FB_TAPS; j++)
        acc -= longint'(coef[int'(REG_A1) + j]) * longint'(y_hist[j]);
      // scale by 1/a0, round half up to Q1.15
      q = (acc * longint'(coef[REG_RECIP]) + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
      if (q > longint'(SAT_MAX)) begin
        r.y    = SAT_MAX;
        r.clip = 1'b1;
      end else if (q < longint'(SAT_MIN)) begin
        r.y    = SAT_MIN;
        r.clip = 1'b1;
      end else begin
        r.y    = q[SAMPLE_W-1:0];
        r.clip = 1'b0;
      end
      for (int j = FWD_TAPS - 1; j >= 1; j--) x_hist[j] = x_hist[j-1];
      x_hist[0] = x;
      for (int j = FB_TAPS - 1; j >= 1; j--) y_hist[j] = y_hist[j-1];
      y_hist[0] = r.y;
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    // Compare one output against the oldest queued prediction
    task check_result(logic signed [SAMPLE_W-1:0] y, logic c);
      filt_result_t exp_r;
      if (expected_q.size() == 0) begin
        report($sformatf("output %0d clipped=%0b with no item pending", y, c));
        return;
      end
      exp_r = expected_q.pop_front();
      results++;
      if (exp_r.clip) clips++;
      if (y !== exp_r.y)
        report($sformatf("output #%0d sample_out %0d, predicted %0d", results, y, exp_r.y));
      if (c !== exp_r.clip)
        report($sformatf("output #%0d clipped %0b, predicted %0b", results, c, exp_r.clip));
    endtask
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0]     cfg_index = '0;
  logic signed [COEF_W-1:0]   cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] sample_in = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       clipped;

  iir_df1_scoreboard sb = new();
  bit                steady_flow = 1'b0;
  int                items_sent = 0;
  int                settings_used = 0;

  iir_direct_form_one_filter_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .clipped    (clipped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 14);
    return $urandom_range(20, 80);
  endfunction

  // Present one item and hold it until the block takes it
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
    @(negedge clk);
    in_valid  = 1'b1;
    sample_in = x;
    do @(posedge clk); while (in_stall);
    sb.note_input(x);
    items_sent++;
  endtask

  // Drop valid and hold it low for the pause given by n
  task automatic pause_sender(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    pause_sender(1);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // Reprogram every register once the block has gone quiet
  task automatic apply_setting(input logic signed [COEF_W-1:0] cset [NUM_REGS]);
    wait_drained();
    repeat (IDLE_WAIT) @(posedge clk);
    for (int i = 0; i < NUM_REGS; i++) begin
      @(negedge clk);
      cfg_wr_en = 1'b1;
      cfg_index = i[CFG_INDEX_W-1:0];
      cfg_data  = cset[i];
      sb.write_reg(i, cset[i]);
    end
    @(negedge clk);
    cfg_wr_en = 1'b0;
    settings_used++;
  endtask

  // Writes to indexes beyond the register file must leave the filter alone
  task automatic poke_unused();
    int idx;
    repeat ($urandom_range(1, 4)) begin
      idx = $urandom_range(NUM_REGS, (1 << CFG_INDEX_W) - 1);
      @(negedge clk);
      cfg_wr_en = 1'b1;
      cfg_index = idx[CFG_INDEX_W-1:0];
      cfg_data  = COEF_W'($urandom());
      sb.write_reg(idx, cfg_data);
    end
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Output side: random stalls, none started during steady stretches
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_stall = 1'b1;
        hold--;
      end else begin
        out_stall = 1'b0;
        if (!steady_flow && $urandom_range(0, 5) == 0) hold = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(sample_out, clipped);
  end

  // Give up when nothing moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_MAX) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
        quiet = 0;
      else
        quiet++;
    end
    $display("iir_direct_form_one_filter_core_tb: errors");
    $finish;
  end

  initial begin
    logic signed [COEF_W-1:0]   cset [NUM_REGS];
    logic signed [SAMPLE_W-1:0] x;
    int                         mode;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset coefficients pass samples straight through
    send_sample(16'sd0);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(16'sd21845);
    send_sample(-16'sd21846);

    // Smallest gain: output lands on rounding halves
    cset = '{1, 0, 0, 0, 0, 0, 0, 16384};
    apply_setting(cset);
    send_sample(16'sd8192);
    send_sample(-16'sd8192);
    send_sample(16'sd24576);
    send_sample(-16'sd24576);

    // Large gain with feedback: saturate both ways
    cset = '{131071, 0, 0, 0, 16384, 0, 0, 16384};
    apply_setting(cset);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(16'sd1);

    // Zero reciprocal forces a zero output
    cset = '{16384, 8192, 8192, 8192, 4096, 4096, 4096, 0};
    apply_setting(cset);
    poke_unused();
    send_sample(16'sd12345);
    send_sample(-16'sd32768);

    // All registers at the negative limit, then at the positive limit
    cset = '{default: -131072};
    apply_setting(cset);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(16'sd32767);
    cset = '{default: 131071};
    apply_setting(cset);
    send_sample(-16'sd32768);
    send_sample(16'sd32767);
    send_sample(16'sd0);

    // Random phases, each with its own coefficient set
    for (int p = 0; p < RAND_PHASES; p++) begin
      mode = (p == 0) ? 1 : $urandom_range(0, 2);
      for (int i = 0; i < NUM_REGS; i++) begin
        case (mode)
          0: cset[i] = COEF_W'($urandom());
          1: begin
            if (i < 4)      cset[i] = COEF_W'(int'($urandom_range(0, 16384)) - 8192);
            else if (i < 7) cset[i] = COEF_W'(int'($urandom_range(0, 8192)) - 4096);
            else            cset[i] = COEF_W'($urandom_range(8192, 24576));
          end
          default: begin
            case ($urandom_range(0, 4))
              0: cset[i] = -131072;
              1: cset[i] = 131071;
              2: cset[i] = 0;
              3: cset[i] = 16384;
              default: cset[i] = -16384;
            endcase
          end
        endcase
      end
      if (mode == 1 && $urandom_range(0, 9) == 0) cset[REG_RECIP] = 0;
      apply_setting(cset);
      if ($urandom_range(0, 2) == 0) poke_unused();
      steady_flow = (p % 4 == 1);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold the sender until the filter has caught up
        if (p == 2 && n == PHASE_ITEMS / 2) wait_drained();
        case ($urandom_range(0, 9))
          0: begin
            case ($urandom_range(0, 3))
              0: x = SAT_MAX;
              1: x = SAT_MIN;
              2: x = '0;
              default: x = -16'sd1;
            endcase
          end
          1, 2, 3: x = SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
          default: x = SAMPLE_W'($urandom());
        endcase
        send_sample(x);
        if (!steady_flow && $urandom_range(0, 2) == 0) pause_sender(gap_len());
      end
      steady_flow = 1'b0;
    end

    // Drain and let any stray output show up
    wait_drained();
    repeat (IDLE_WAIT + 4) @(posedge clk);

    $display("run covered %0d items under %0d coefficient settings plus reset values",
             items_sent, settings_used);
    $display("checked %0d outputs, %0d of them saturated, %0d mismatches",
             sb.results, sb.clips, sb.errors);
    if (sb.errors == 0) begin
      $display("iir_direct_form_one_filter_core_tb: clean");
    end else begin
      $display("iir_direct_form_one_filter_core_tb: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
design/iirdf1_pkg.sv
design/iirdf1_seq.sv
design/iirdf1_dp.sv
design/iir_direct_form_one_filter_core.sv
tb/iir_direct_form_one_filter_core_tb.sv
